// ===== hdl/tgd_pkg.sv =====
// Shared types, constants and tables of the tilt gesture detector.
// Used by the controller, the datapath, the top level and the checker.
package tgd_pkg;

	localparam int ANGLE_W      = 14;
	localparam int TILT_W       = 15;
	localparam int ACCEL_W      = 16;
	localparam int ACC_W        = 28;
	localparam int ROOT_W       = 28;
	localparam int CORDIC_STEPS = 20;
	localparam int ROOT_STEPS   = 28;
	localparam int CNT_W        = 5;

	localparam logic [ACC_W-1:0] QUARTER_TURN = 28'd47185920;
	localparam logic [26:0]      ROUND_HALF   = 27'd2048;

	localparam logic [24:0] ATAN_TAB [CORDIC_STEPS] = '{
		25'd23592960, 25'd13927738, 25'd7359034, 25'd3735561, 25'd1875029,
		25'd938429,   25'd469328,   25'd234678,  25'd117341,  25'd58671,
		25'd29335,    25'd14668,    25'd7334,    25'd3667,    25'd1833,
		25'd917,      25'd458,      25'd229,     25'd115,     25'd57
	};

	localparam logic [ANGLE_W-1:0] TRIGGER_RESET = 14'd2560;
	localparam logic [ANGLE_W-1:0] REARM_RESET   = 14'd1280;
	localparam logic [ANGLE_W-1:0] LEAN_RESET    = 14'd640;

	localparam logic [1:0] REG_TRIGGER = 2'd0;
	localparam logic [1:0] REG_REARM   = 2'd1;
	localparam logic [1:0] REG_LEAN    = 2'd2;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	localparam logic [3:0] IND_FLAT       = 4'd0;
	localparam logic [3:0] IND_LEAN_LEFT  = 4'd1;
	localparam logic [3:0] IND_LEAN_RIGHT = 4'd2;
	localparam logic [3:0] IND_LEAN_UP    = 4'd3;
	localparam logic [3:0] IND_LEAN_DOWN  = 4'd4;
	localparam logic [3:0] IND_MOVE_LEFT  = 4'd5;
	localparam logic [3:0] IND_MOVE_RIGHT = 4'd6;
	localparam logic [3:0] IND_MOVE_UP    = 4'd7;
	localparam logic [3:0] IND_MOVE_DOWN  = 4'd8;

	typedef enum logic {
		AXIS_PITCH,
		AXIS_ROLL
	} tgd_axis_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_CORDIC_LOAD,
		ST_CORDIC,
		ST_STORE,
		ST_FINISH
	} tgd_state_t;

	typedef struct packed {
		logic             load;
		logic             square;
		logic             root_load;
		logic             root_step;
		logic             cordic_load;
		logic             cordic_step;
		logic             store;
		logic             finish;
		tgd_axis_t        axis;
		logic [CNT_W-1:0] step;
	} tgd_cmd_t;

	typedef struct packed {
		logic ok;
		logic out_busy;
	} tgd_stat_t;

endpackage

// ===== hdl/tgd_ctrl.sv =====
// Sequencing state machine of the tilt gesture detector.
// Depends on tgd_pkg; drives the datapath through tgd_cmd_t.
module tgd_ctrl import tgd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tgd_stat_t stat,
	output tgd_cmd_t  cmd
);

	tgd_state_t       state_q, state_d;
	tgd_axis_t        axis_q, axis_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_PITCH;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.axis = axis_q;
		cmd.step = cnt_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					axis_d   = AXIS_PITCH;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (!stat.ok) begin
					state_d = ST_FINISH;
				end else begin
					cmd.square = 1'b1;
					state_d    = ST_ROOT_LOAD;
				end
			end
			ST_ROOT_LOAD: begin
				cmd.root_load = 1'b1;
				cnt_d         = '0;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_CORDIC_LOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CORDIC_LOAD: begin
				cmd.cordic_load = 1'b1;
				state_d         = ST_CORDIC;
			end
			ST_CORDIC: begin
				cmd.cordic_step = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_STORE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (axis_q == AXIS_PITCH) begin
					axis_d  = AXIS_ROLL;
					state_d = ST_SQUARE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/tgd_dp.sv =====
// Datapath: squares, bit-serial square root, vectoring CORDIC, gesture
// decision, configuration registers and the result register. Uses tgd_pkg.
module tgd_dp import tgd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tgd_cmd_t                  cmd,
	output tgd_stat_t                 stat,
	input  logic                      sample_ok,
	input  logic signed [ACCEL_W-1:0] accel_x,
	input  logic signed [ACCEL_W-1:0] accel_y,
	input  logic signed [ACCEL_W-1:0] accel_z,
	input  logic                      cfg_valid,
	input  logic [1:0]                cfg_index,
	input  logic [ANGLE_W-1:0]        cfg_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic                      move_fired,
	output logic [1:0]                move_dir,
	output logic [3:0]                indication,
	output logic signed [TILT_W-1:0]  tilt_angle
);

	logic                      ok_q;
	logic signed [ACCEL_W-1:0] x_q, y_q, z_q;
	logic [30:0]               sq_b_q, sq_c_q;
	logic [55:0]               v_q;
	logic [29:0]               rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic signed [31:0]        cx_q, cy_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [ANGLE_W-1:0]        pmag_q, rmag_q;
	logic                      pneg_q, rneg_q;
	logic [ANGLE_W-1:0]        trig_q, rearm_q, lean_q;
	logic                      pending_q;
	logic                      out_valid_q;
	logic                      fired_q;
	logic [1:0]                dir_q;
	logic [3:0]                ind_q;
	logic signed [TILT_W-1:0]  tilt_q;

	// operand selection per axis
	logic signed [ACCEL_W-1:0] sel_a, sel_b;
	logic signed [31:0]        prod_b, prod_c;
	logic [31:0]               sum_sq;
	logic signed [ACCEL_W:0]   a_ext;
	logic [ACCEL_W:0]          abs_a;

	assign sel_a  = (cmd.axis == AXIS_PITCH) ? x_q : y_q;
	assign sel_b  = (cmd.axis == AXIS_PITCH) ? y_q : x_q;
	assign prod_b = 32'(sel_b) * 32'(sel_b);
	assign prod_c = 32'(z_q) * 32'(z_q);
	assign sum_sq = {1'b0, sq_b_q} + {1'b0, sq_c_q};
	assign a_ext  = {sel_a[ACCEL_W-1], sel_a};
	assign abs_a  = a_ext[ACCEL_W] ? $unsigned(-a_ext) : $unsigned(a_ext);

	// square root step
	logic [31:0] rem_sh, trial, rem_sub;
	logic        take;

	assign rem_sh  = {rem_q, v_q[55:54]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign take    = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	// CORDIC step
	logic signed [31:0]      dx, dy;
	logic signed [ACC_W-1:0] atan_i;

	assign dx     = cy_q >>> cmd.step;
	assign dy     = cx_q >>> cmd.step;
	assign atan_i = $signed({3'b000, ATAN_TAB[cmd.step]});

	// clamp and round the accumulated angle
	logic [25:0]        acc_c;
	logic [26:0]        acc_r;
	logic [ANGLE_W-1:0] mag;

	always_comb begin
		if (acc_q[ACC_W-1]) begin
			acc_c = '0;
		end else if (acc_q > $signed(QUARTER_TURN)) begin
			acc_c = QUARTER_TURN[25:0];
		end else begin
			acc_c = acc_q[25:0];
		end
		acc_r = {1'b0, acc_c} + ROUND_HALF;
		mag   = (sel_a == '0) ? '0 : acc_r[25:12];
	end

	// gesture decision
	logic               pitch_dom, dneg, past, leaned, rearmed, pend_eff, fire;
	logic [ANGLE_W-1:0] dmag;
	logic [1:0]         dir;
	logic [3:0]         move_ind, lean_ind, ind;
	logic [TILT_W-1:0]  tilt;

	always_comb begin
		pitch_dom = pmag_q > rmag_q;
		dmag      = pitch_dom ? pmag_q : rmag_q;
		dneg      = pitch_dom ? pneg_q : rneg_q;
		past      = dmag > trig_q;
		leaned    = dmag > lean_q;
		if (pitch_dom) begin
			dir      = dneg ? DIR_UP : DIR_DOWN;
			lean_ind = dneg ? IND_LEAN_UP : IND_LEAN_DOWN;
		end else begin
			dir      = dneg ? DIR_LEFT : DIR_RIGHT;
			lean_ind = dneg ? IND_LEAN_LEFT : IND_LEAN_RIGHT;
		end
		case (dir)
			DIR_LEFT:  move_ind = IND_MOVE_LEFT;
			DIR_RIGHT: move_ind = IND_MOVE_RIGHT;
			DIR_UP:    move_ind = IND_MOVE_UP;
			DIR_DOWN:  move_ind = IND_MOVE_DOWN;
			default:   move_ind = IND_FLAT;
		endcase
		if (past) begin
			ind = move_ind;
		end else if (leaned) begin
			ind = lean_ind;
		end else begin
			ind = IND_FLAT;
		end
		rearmed  = pending_q && (pmag_q < rearm_q) && (rmag_q < rearm_q);
		pend_eff = pending_q && !rearmed;
		fire     = !pend_eff && past;
		tilt     = dneg ? TILT_W'(-{1'b0, dmag}) : {1'b0, dmag};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q <= sample_ok;
			x_q  <= accel_x;
			y_q  <= accel_y;
			z_q  <= accel_z;
		end
		if (cmd.square) begin
			sq_b_q <= prod_b[30:0];
			sq_c_q <= prod_c[30:0];
		end
		if (cmd.root_load) begin
			v_q    <= {sum_sq, 24'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			v_q <= {v_q[53:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sub[29:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[29:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.cordic_load) begin
			cx_q  <= $signed({4'b0000, root_q});
			cy_q  <= $signed({3'b000, abs_a, 12'd0});
			acc_q <= '0;
		end else if (cmd.cordic_step) begin
			if (!cy_q[31]) begin
				cx_q  <= cx_q + dx;
				cy_q  <= cy_q - dy;
				acc_q <= acc_q + atan_i;
			end else begin
				cx_q  <= cx_q - dx;
				cy_q  <= cy_q + dy;
				acc_q <= acc_q - atan_i;
			end
		end
		if (cmd.store) begin
			if (cmd.axis == AXIS_PITCH) begin
				pmag_q <= mag;
				pneg_q <= sel_a[ACCEL_W-1];
			end else begin
				rmag_q <= mag;
				rneg_q <= sel_a[ACCEL_W-1];
			end
		end
		if (cmd.finish) begin
			if (ok_q) begin
				fired_q <= fire;
				dir_q   <= fire ? dir : DIR_LEFT;
				ind_q   <= ind;
				tilt_q  <= $signed(tilt);
			end else begin
				fired_q <= 1'b0;
				dir_q   <= DIR_LEFT;
				ind_q   <= IND_FLAT;
				tilt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q      <= TRIGGER_RESET;
			rearm_q     <= REARM_RESET;
			lean_q      <= LEAN_RESET;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TRIGGER: trig_q  <= cfg_data;
					REG_REARM:   rearm_q <= cfg_data;
					REG_LEAN:    lean_q  <= cfg_data;
					default:     ;
				endcase
			end
			if (cmd.finish && ok_q) begin
				pending_q <= fire || pend_eff;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.ok       = ok_q;
	assign stat.out_busy = out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign move_fired = fired_q;
	assign move_dir   = dir_q;
	assign indication = ind_q;
	assign tilt_angle = tilt_q;

endmodule

// ===== hdl/tilt_gesture_detector_top.sv =====
// Top level of the tilt gesture detector: controller plus datapath.
// Depends on tgd_pkg, tgd_ctrl and tgd_dp.
//
// One sample is worked at a time. Per axis a good sample passes through
// squaring, a bit-serial square root and a CORDIC with load and store
// states, run first for pitch and then for roll on the same unit,
// followed by the decision. A failed read goes straight to the decision,
// which waits while an earlier result is still stalled. The result sits in
// an output register, so the next sample is taken while it waits for its
// transfer. Configuration writes are always ready and are meant for when
// the block is idle; an index past the last register is dropped.
module tilt_gesture_detector_top import tgd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      sample_ok,
	input  logic signed [ACCEL_W-1:0] accel_x,
	input  logic signed [ACCEL_W-1:0] accel_y,
	input  logic signed [ACCEL_W-1:0] accel_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      move_fired,
	output logic [1:0]                move_dir,
	output logic [3:0]                indication,
	output logic signed [TILT_W-1:0]  tilt_angle,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [ANGLE_W-1:0]        cfg_data
);

	tgd_cmd_t  cmd;
	tgd_stat_t stat;

	assign cfg_ready = 1'b1;

	tgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tgd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample_ok  (sample_ok),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.move_fired (move_fired),
		.move_dir   (move_dir),
		.indication (indication),
		.tilt_angle (tilt_angle)
	);

endmodule

// ===== hdl/tgd_checker.sv =====
// Port-level checks of the tilt gesture detector, bound to its top level.
// Depends on tgd_pkg.
module tgd_checker import tgd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      move_fired,
	input logic [1:0]                move_dir,
	input logic [3:0]                indication,
	input logic signed [TILT_W-1:0]  tilt_angle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new sample taken while one is in work");

	a_fire_ind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_fired |-> indication == IND_MOVE_LEFT + 4'(move_dir))
		else $error("move indication does not match direction");

	a_idle_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !move_fired |-> move_dir == DIR_LEFT)
		else $error("direction set without a move");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tilt_angle <= 15'sd11520 && tilt_angle >= -15'sd11520)
		else $error("tilt angle out of range");

endmodule

bind tilt_gesture_detector_top tgd_checker u_tgd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.move_fired (move_fired),
	.move_dir   (move_dir),
	.indication (indication),
	.tilt_angle (tilt_angle)
);
